// File: sv/lsdp_pkg.sv
`default_nettype none
package lsdp_pkg;

  localparam int ADDR_W      = 32;
  localparam int SET_BITS    = 6;
  localparam int NUM_SETS    = 1 << SET_BITS;
  localparam int STACK_DEPTH = 16;
  localparam int POS_W       = $clog2(STACK_DEPTH);
  localparam int SEQ_ROWS    = 256;
  localparam int ROW_SEL_W   = $clog2(SEQ_ROWS);
  localparam int CNT_W       = $clog2(SEQ_ROWS + 1);
  localparam int TAG_W       = ADDR_W - SET_BITS;
  localparam int HIST_DEPTH  = SEQ_ROWS * STACK_DEPTH;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);
  localparam int CLR_W       = HIST_AW + 1;
  localparam int VAL_W       = 32;
  localparam int BOFF_W      = 4;
  localparam logic [BOFF_W-1:0] BOFF_RESET = 4'd6;
  localparam logic [VAL_W-1:0]  SAT32      = '1;

  typedef enum logic [1:0] {
    OP_ACCESS   = 2'd0,
    OP_RD_HIST  = 2'd1,
    OP_RD_HITS  = 2'd2,
    OP_RD_MISS  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_HINC
  } state_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [ADDR_W-1:0]   address;
    logic                counting_enabled;
    logic [7:0]          hist_row;
    logic [3:0]          hist_column;
  } in_t;

  typedef struct packed {
    logic                hit;
    logic [3:0]          stack_position;
    logic [8:0]          sequence_length;
    logic [VAL_W-1:0]    read_value;
  } out_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef entry_t [STACK_DEPTH-1:0] row_t;

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v >= CNT_W'(SEQ_ROWS)) r = CNT_W'(SEQ_ROWS);
    else r = v + 1'b1;
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] sat32(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] r;
    if (v == SAT32) r = v;
    else r = v + 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/lsdp_ram.sv
`default_nettype none
module lsdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/lru_stack_distance_profiler.sv
`default_nettype none
// lru stack distance profiler
// commands enter on start/cmd and are taken when start is high and busy low.
// opcode access looks the address up in its set's lru stack, moves the entry
// to the top and ages the others; read opcodes return a histogram cell or a
// hit or miss total. each command gives one result word on result, marked by
// a one-cycle done strobe; the receiver cannot stall, so nothing is held back.
// the stack row or histogram cell is read from a registered-output ram, then
// compared and written back; reads, misses and uncounted hits end in the look
// state, a counted hit adds a read-modify-write of the histogram cell. busy
// stays high until the result is out, so one command is in flight at a time.
// cfg_valid/cfg_ready/cfg_data write block_offset_bits (always ready); write
// it only while idle.
// reset: stack rows read as empty via per-set valid bits; the histogram ram is
// swept to zero (all 4096 cells) with busy high; totals clear, offset goes to 6.
module lru_stack_distance_profiler (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire lsdp_pkg::in_t        cmd,
  output logic                      done,
  output lsdp_pkg::out_t            result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [lsdp_pkg::BOFF_W-1:0] cfg_data
);

  lsdp_pkg::state_t state, state_next;
  lsdp_pkg::in_t    cmd_q;
  logic [lsdp_pkg::SET_BITS-1:0] set_q, set_in;
  logic [lsdp_pkg::TAG_W-1:0]    tag_q, tag_in;
  logic [lsdp_pkg::BOFF_W-1:0]   boff;
  logic [lsdp_pkg::VAL_W-1:0]    hit_total, miss_total;
  logic [lsdp_pkg::CLR_W-1:0]    clr_cnt;
  logic [lsdp_pkg::NUM_SETS-1:0] set_valid;
  logic                          row_valid_q;
  lsdp_pkg::out_t                res_q, res_next;
  logic                          done_next;
  logic [lsdp_pkg::HIST_AW-1:0]  hinc_addr, hinc_addr_next;

  logic                          s_we;
  lsdp_pkg::row_t                s_wdata, s_rdata, row_old;
  logic [lsdp_pkg::SET_BITS-1:0] s_raddr;
  logic                          h_we;
  logic [lsdp_pkg::HIST_AW-1:0]  h_waddr, h_raddr;
  logic [lsdp_pkg::VAL_W-1:0]    h_wdata, h_rdata;

  logic                          found;
  logic [lsdp_pkg::POS_W-1:0]    pos, lim;
  logic [lsdp_pkg::CNT_W-1:0]    n;
  logic [lsdp_pkg::ROW_SEL_W-1:0] n_m1;
  logic [lsdp_pkg::ADDR_W-1:0]   shifted, tshifted;
  logic                          accept;

  assign accept    = start && !busy;
  assign busy      = (state != lsdp_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  assign shifted  = cmd.address >> boff;
  assign tshifted = cmd.address >> ({1'b0, boff} + 5'(lsdp_pkg::SET_BITS));
  assign set_in   = shifted[lsdp_pkg::SET_BITS-1:0];
  assign tag_in   = tshifted[lsdp_pkg::TAG_W-1:0];

  lsdp_ram #(
    .WIDTH ($bits(lsdp_pkg::row_t)),
    .DEPTH (lsdp_pkg::NUM_SETS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (set_q),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  lsdp_ram #(
    .WIDTH (lsdp_pkg::VAL_W),
    .DEPTH (lsdp_pkg::HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  assign s_raddr = set_in;
  assign row_old = row_valid_q ? s_rdata : '0;

  // lowest matching position wins
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = lsdp_pkg::STACK_DEPTH - 1; i >= 0; i--) begin
      if (row_old[i].tag == tag_q) begin
        found = 1'b1;
        pos   = lsdp_pkg::POS_W'(i);
      end
    end
    n    = lsdp_pkg::sat_cnt(row_old[pos].count);
    n_m1 = lsdp_pkg::ROW_SEL_W'(n - 1'b1);
    lim  = found ? pos : lsdp_pkg::POS_W'(lsdp_pkg::STACK_DEPTH - 1);
  end

  // shifted and aged row
  always_comb begin
    s_wdata = row_old;
    s_wdata[0].tag   = tag_q;
    s_wdata[0].count = lsdp_pkg::CNT_W'(1);
    for (int i = 1; i < lsdp_pkg::STACK_DEPTH; i++) begin
      if (lsdp_pkg::POS_W'(i) <= lim) begin
        s_wdata[i] = row_old[i-1];
      end
      if (s_wdata[i].tag != '0) begin
        s_wdata[i].count = lsdp_pkg::sat_cnt(s_wdata[i].count);
      end
    end
  end

  always_comb begin
    state_next     = state;
    s_we           = 1'b0;
    h_we           = 1'b0;
    h_waddr        = hinc_addr;
    h_wdata        = lsdp_pkg::sat32(h_rdata);
    h_raddr        = {cmd.hist_row, cmd.hist_column};
    done_next      = 1'b0;
    res_next       = res_q;
    hinc_addr_next = hinc_addr;
    case (state)
      lsdp_pkg::S_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = clr_cnt[lsdp_pkg::HIST_AW-1:0];
        h_wdata = '0;
        if (clr_cnt == lsdp_pkg::CLR_W'(lsdp_pkg::HIST_DEPTH - 1)) begin
          state_next = lsdp_pkg::S_IDLE;
        end
      end
      lsdp_pkg::S_IDLE: begin
        if (accept) begin
          state_next = lsdp_pkg::S_LOOK;
        end
      end
      lsdp_pkg::S_LOOK: begin
        res_next = '0;
        case (cmd_q.opcode)
          lsdp_pkg::OP_ACCESS: begin
            s_we = 1'b1;
            if (found) begin
              res_next.hit             = 1'b1;
              res_next.stack_position  = pos;
              res_next.sequence_length = n;
            end
            hinc_addr_next = {n_m1, pos};
            h_raddr        = {n_m1, pos};
            if (found && cmd_q.counting_enabled) begin
              state_next = lsdp_pkg::S_HINC;
            end else begin
              state_next = lsdp_pkg::S_IDLE;
              done_next  = 1'b1;
            end
          end
          lsdp_pkg::OP_RD_HIST: begin
            res_next.read_value = h_rdata;
            state_next = lsdp_pkg::S_IDLE;
            done_next  = 1'b1;
          end
          lsdp_pkg::OP_RD_HITS: begin
            res_next.read_value = hit_total;
            state_next = lsdp_pkg::S_IDLE;
            done_next  = 1'b1;
          end
          default: begin
            res_next.read_value = miss_total;
            state_next = lsdp_pkg::S_IDLE;
            done_next  = 1'b1;
          end
        endcase
      end
      lsdp_pkg::S_HINC: begin
        h_we       = 1'b1;
        state_next = lsdp_pkg::S_IDLE;
        done_next  = 1'b1;
      end
      default: begin
        state_next = lsdp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lsdp_pkg::S_CLEAR;
      clr_cnt    <= '0;
      boff       <= lsdp_pkg::BOFF_RESET;
      hit_total  <= '0;
      miss_total <= '0;
      set_valid  <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == lsdp_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        boff <= cfg_data;
      end
      if (s_we) begin
        set_valid[set_q] <= 1'b1;
      end
      if (state == lsdp_pkg::S_LOOK && cmd_q.opcode == lsdp_pkg::OP_ACCESS
          && cmd_q.counting_enabled) begin
        if (found) begin
          hit_total <= lsdp_pkg::sat32(hit_total);
        end else begin
          miss_total <= lsdp_pkg::sat32(miss_total);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      set_q <= set_in;
      tag_q <= tag_in;
    end
    row_valid_q <= set_valid[s_raddr];
    res_q       <= res_next;
    hinc_addr   <= hinc_addr_next;
    result      <= res_next;
  end

endmodule
`default_nettype wire

// File: verif/testbench.sv
`default_nettype none
module testbench;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  lsdp_pkg::in_t cmd = '0;
  logic done;
  lsdp_pkg::out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lsdp_pkg::BOFF_W-1:0] cfg_data = '0;

  lru_stack_distance_profiler uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] set_tag [lsdp_pkg::NUM_SETS][lsdp_pkg::STACK_DEPTH];
  int unsigned set_cnt [lsdp_pkg::NUM_SETS][lsdp_pkg::STACK_DEPTH];
  logic [31:0] seq_hist [lsdp_pkg::HIST_DEPTH];
  logic [31:0] hits_seen, misses_seen;
  logic [3:0] offset_bits;

  lsdp_pkg::in_t cmd_queue[$];
  lsdp_pkg::out_t expected_words[$];
  int send_idle_pct = 35;
  bit drain_hold = 1'b0;
  int failures = 0;
  int cycles = 0;

  function automatic logic [31:0] inc32(logic [31:0] v);
    return (v == '1) ? v : v + 1;
  endfunction

  function automatic int unsigned inc_cnt(int unsigned v);
    return (v >= lsdp_pkg::SEQ_ROWS) ? lsdp_pkg::SEQ_ROWS : v + 1;
  endfunction

  function automatic lsdp_pkg::out_t predict_word(lsdp_pkg::in_t c);
    lsdp_pkg::out_t w;
    int unsigned s, sh, p, n;
    logic [31:0] tg;
    bit found;
    w = '0;
    case (lsdp_pkg::opcode_t'(c.opcode))
      lsdp_pkg::OP_ACCESS: begin
        s = (c.address >> offset_bits) & (lsdp_pkg::NUM_SETS - 1);
        sh = offset_bits + lsdp_pkg::SET_BITS;
        tg = (sh >= 32) ? 32'd0 : c.address >> sh;
        found = 0;
        p = lsdp_pkg::STACK_DEPTH - 1;
        for (int i = 0; i < lsdp_pkg::STACK_DEPTH; i++)
          if (!found && set_tag[s][i] == tg) begin
            found = 1;
            p = i;
          end
        n = inc_cnt(set_cnt[s][p]);
        if (n == 0) n = 1;
        for (int i = p; i > 0; i--) begin
          set_tag[s][i] = set_tag[s][i-1];
          set_cnt[s][i] = set_cnt[s][i-1];
        end
        set_tag[s][0] = tg;
        set_cnt[s][0] = 1;
        for (int i = 1; i < lsdp_pkg::STACK_DEPTH; i++)
          if (set_tag[s][i] != 0) set_cnt[s][i] = inc_cnt(set_cnt[s][i]);
        if (found) begin
          if (c.counting_enabled) begin
            hits_seen = inc32(hits_seen);
            seq_hist[(n-1)*lsdp_pkg::STACK_DEPTH+p] =
              inc32(seq_hist[(n-1)*lsdp_pkg::STACK_DEPTH+p]);
          end
          w.hit = 1'b1;
          w.stack_position = 4'(p);
          w.sequence_length = 9'(n);
        end else if (c.counting_enabled) begin
          misses_seen = inc32(misses_seen);
        end
      end
      lsdp_pkg::OP_RD_HIST: begin
        if (c.hist_row < lsdp_pkg::SEQ_ROWS && c.hist_column < lsdp_pkg::STACK_DEPTH)
          w.read_value = seq_hist[c.hist_row*lsdp_pkg::STACK_DEPTH + c.hist_column];
      end
      lsdp_pkg::OP_RD_HITS: w.read_value = hits_seen;
      default: w.read_value = misses_seen;
    endcase
    return w;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (start && !busy) begin
        expected_words.push_back(predict_word(cmd));
        void'(cmd_queue.pop_front());
      end
      if (start && busy) begin
        // hold the word until taken
      end else begin
        if (cmd_queue.size() > 0 && !drain_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          start <= 1'b1;
          cmd <= cmd_queue[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %p", $time, result);
        failures++;
      end else begin
        lsdp_pkg::out_t e;
        e = expected_words.pop_front();
        if (e.hit !== result.hit || e.stack_position !== result.stack_position ||
            e.sequence_length !== result.sequence_length ||
            e.read_value !== result.read_value) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, result);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("lru_stack_distance_profiler verification failed");
      $finish;
    end
  end

  function automatic lsdp_pkg::in_t rand_cmd(logic [31:0] base_pool[$]);
    lsdp_pkg::in_t c;
    c.opcode = ($urandom_range(99) < 80) ? 2'(lsdp_pkg::OP_ACCESS) :
                                           2'($urandom_range(1, 3));
    if ($urandom_range(3) == 0) c.address = $urandom();
    else c.address = base_pool[$urandom_range(base_pool.size() - 1)] ^
                     ($urandom_range(7) << $urandom_range(0, 28));
    c.counting_enabled = $urandom_range(9) != 0;
    c.hist_row = ($urandom_range(1) == 0) ? 8'($urandom_range(7)) : 8'($urandom());
    c.hist_column = 4'($urandom());
    return c;
  endfunction

  task automatic wait_idle();
    while (cmd_queue.size() != 0 || start || expected_words.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_offset(logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    offset_bits = v;
  endtask

  task automatic push(logic [1:0] op, logic [31:0] a, logic ce, logic [7:0] r,
                      logic [3:0] col);
    lsdp_pkg::in_t c;
    c.opcode = op;
    c.address = a;
    c.counting_enabled = ce;
    c.hist_row = r;
    c.hist_column = col;
    cmd_queue.push_back(c);
  endtask

  initial begin
    logic [31:0] pool[$];
    logic [3:0] offsets[4] = '{4'd6, 4'd0, 4'd12, 4'd15};
    for (int s = 0; s < lsdp_pkg::NUM_SETS; s++)
      for (int i = 0; i < lsdp_pkg::STACK_DEPTH; i++) begin
        set_tag[s][i] = 0;
        set_cnt[s][i] = 0;
      end
    foreach (seq_hist[i]) seq_hist[i] = 0;
    hits_seen = 0;
    misses_seen = 0;
    offset_bits = lsdp_pkg::BOFF_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero tag hit, extremes, all reads, last histogram row
    push(lsdp_pkg::OP_ACCESS, 32'h0, 1'b1, 8'd0, 4'd0);
    push(lsdp_pkg::OP_ACCESS, 32'hFFFF_FFFF, 1'b1, 8'd0, 4'd0);
    push(lsdp_pkg::OP_ACCESS, 32'hFFFF_FFFF, 1'b1, 8'd0, 4'd0);
    push(lsdp_pkg::OP_ACCESS, 32'h0000_1000, 1'b0, 8'd0, 4'd0);
    push(lsdp_pkg::OP_ACCESS, 32'h0, 1'b1, 8'd0, 4'd0);
    for (int i = 0; i < 17; i++)
      push(lsdp_pkg::OP_ACCESS, 32'((i + 1) << 12), 1'b1, 8'd0, 4'd0);
    push(lsdp_pkg::OP_ACCESS, 32'h0000_1000, 1'b1, 8'd0, 4'd0);
    push(lsdp_pkg::OP_RD_HIST, 32'h0, 1'b0, 8'd0, 4'd0);
    push(lsdp_pkg::OP_RD_HIST, 32'h0, 1'b1, 8'hFF, 4'hF);
    push(lsdp_pkg::OP_RD_HITS, 32'hFFFF_FFFF, 1'b0, 8'd0, 4'd0);
    push(lsdp_pkg::OP_RD_MISS, 32'h0, 1'b0, 8'd0, 4'd0);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      write_offset(offsets[ph]);
      send_idle_pct = (ph == 1) ? 71 : (ph >= 2 ? 0 : 35);
      pool.delete();
      for (int i = 0; i < 6; i++) pool.push_back($urandom());
      for (int k = 0; k < 185; k++) begin
        cmd_queue.push_back(rand_cmd(pool));
        if (k == 90) begin
          // pause until every word is back
          wait_idle();
          drain_hold = 1'b1;
          repeat (3) @(posedge clk);
          drain_hold = 1'b0;
        end
      end
      wait_idle();
    end
    write_offset(lsdp_pkg::BOFF_RESET);
    repeat (20) @(posedge clk);
    if (failures == 0)
      $display("lru_stack_distance_profiler verification clean");
    else
      $display("lru_stack_distance_profiler verification failed");
    $finish;
  end
endmodule
`default_nettype wire
